// ===== hdl/irq_timer_controller_defines.svh =====
// Assertion macros shared by the checker files of the interrupt and timer controller.
// Macros expect aclk and aresetn to be visible in the scope of their use.
`ifndef IRQ_TIMER_CONTROLLER_DEFINES_SVH
`define IRQ_TIMER_CONTROLLER_DEFINES_SVH

// Same-cycle implication, inactive during reset
`define ITC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive during reset
`define ITC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked while reset is applied
`define ITC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/itc_pkg.sv =====
// Shared constants for the interrupt and timer controller.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package itc_pkg;

    // Defaults of the top-level parameters
    localparam int EXT_IRQ_DEPTH_DEF = 64;
    localparam int PC_BITS_DEF       = 12;
    localparam int DISK_PERIOD_DEF   = 1024;

    // Data widths
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int IDX_W    = 6;
    localparam int IRQ_SRCS = 3;

    // Configuration port
    localparam int CFG_CNT_W  = 7;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] CFG_IDX_EXT_IRQ_COUNT = '0;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_IO_WRITE   = 3'd1;
    localparam logic [OP_W-1:0] OP_IO_READ    = 3'd2;
    localparam logic [OP_W-1:0] OP_IRQ_RETURN = 3'd3;
    localparam logic [OP_W-1:0] OP_TABLE_LOAD = 3'd4;

    // I/O register numbers
    localparam logic [IDX_W-1:0] IO_ENABLE0    = 6'd0;
    localparam logic [IDX_W-1:0] IO_ENABLE1    = 6'd1;
    localparam logic [IDX_W-1:0] IO_ENABLE2    = 6'd2;
    localparam logic [IDX_W-1:0] IO_STATUS0    = 6'd3;
    localparam logic [IDX_W-1:0] IO_STATUS1    = 6'd4;
    localparam logic [IDX_W-1:0] IO_STATUS2    = 6'd5;
    localparam logic [IDX_W-1:0] IO_HANDLER    = 6'd6;
    localparam logic [IDX_W-1:0] IO_RETURN     = 6'd7;
    localparam logic [IDX_W-1:0] IO_TIMER_ON   = 6'd8;
    localparam logic [IDX_W-1:0] IO_TIMER_CNT  = 6'd9;
    localparam logic [IDX_W-1:0] IO_TIMER_LIM  = 6'd10;
    localparam logic [IDX_W-1:0] IO_CYCLE_CNT  = 6'd11;

    // Interrupt source bit positions
    localparam int SRC_TIMER = 0;
    localparam int SRC_DISK  = 1;
    localparam int SRC_EXT   = 2;

endpackage

`default_nettype wire

// ===== hdl/irq_timer_controller.sv =====
// Interrupt and timer controller: interrupt entry, timer, disk tick, cycle table, I/O registers.
// Depends on itc_pkg and itc_ram.
//
//  channel   ports                     direction  payload
//  input     s_valid / s_ready         in         opcode, current_pc, big_imm_pending,
//                                                 target_index, write_value
//  result    m_valid / m_ready         out        take_interrupt, fetch_pc, read_data
//  config    psel / penable / pready   in (APB)   ext_irq_count at byte address 0
//
// One item per clock while the result side does not stall; each item passes from the input register
// on to the result register, which raises valid once it holds the item.
// The cycle table sits in a RAM that is read ahead at the next position every cycle.
// Reset is synchronous and clears all control and architectural state; no clearing pass.
// A stalled result holds; the input register still takes one more item meanwhile.
`default_nettype none

module irq_timer_controller
    import itc_pkg::*;
#(
    parameter int EXT_IRQ_DEPTH = EXT_IRQ_DEPTH_DEF,
    parameter int PC_BITS       = PC_BITS_DEF,
    parameter int DISK_PERIOD   = DISK_PERIOD_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OP_W-1:0]       s_opcode,
    input  wire logic [PC_BITS-1:0]    s_current_pc,
    input  wire logic                  s_big_imm_pending,
    input  wire logic [IDX_W-1:0]      s_target_index,
    input  wire logic [DATA_W-1:0]     s_write_value,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_take_interrupt,
    output logic [PC_BITS-1:0]         m_fetch_pc,
    output logic [DATA_W-1:0]          m_read_data,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    localparam int AW     = (EXT_IRQ_DEPTH > 1) ? $clog2(EXT_IRQ_DEPTH) : 1;
    localparam int CNT_W  = (AW + 1 > CFG_CNT_W) ? AW + 1 : CFG_CNT_W;
    localparam int DISK_W = (DISK_PERIOD > 1) ? $clog2(DISK_PERIOD) : 1;

    // configuration register
    logic [CFG_CNT_W-1:0] cfg_count_reg;
    logic                 cfg_sel;

    // input register
    logic                 in_valid_reg, in_valid_next;
    logic [OP_W-1:0]      op_reg;
    logic [PC_BITS-1:0]   pc_reg;
    logic                 bigimm_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [DATA_W-1:0]    val_reg;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic                 take_reg, take_next;
    logic [PC_BITS-1:0]   fetch_reg, fetch_next;
    logic [DATA_W-1:0]    rdata_reg, rdata_next;

    // architectural state
    logic [IRQ_SRCS-1:0]  en_reg, en_next;
    logic [IRQ_SRCS-1:0]  st_reg, st_next;
    logic [PC_BITS-1:0]   handler_reg, handler_next;
    logic [PC_BITS-1:0]   ret_reg, ret_next;
    logic                 in_handler_reg, in_handler_next;
    logic                 timer_on_reg, timer_on_next;
    logic [DATA_W-1:0]    timer_cnt_reg, timer_cnt_next;
    logic [DATA_W-1:0]    timer_lim_reg, timer_lim_next;
    logic [DATA_W-1:0]    cycle_reg, cycle_next;
    logic [DISK_W-1:0]    disk_reg, disk_next;
    logic [AW-1:0]        pos_reg, pos_next;

    // cycle table access
    logic                 tbl_we;
    logic [AW-1:0]        tbl_waddr;
    logic [AW-1:0]        tbl_raddr;
    logic [DATA_W-1:0]    tbl_q;
    logic                 byp_valid_reg;
    logic [DATA_W-1:0]    byp_data_reg;
    logic [DATA_W-1:0]    tbl_entry;
    logic [CNT_W-1:0]     eff_count;
    logic [CNT_W-1:0]     pos_ext;

    logic                 out_free;
    logic                 fire;
    logic                 accept;

    // Handshake
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    assign m_valid          = m_valid_reg;
    assign m_take_interrupt = take_reg;
    assign m_fetch_pc       = fetch_reg;
    assign m_read_data      = rdata_reg;

    // Configuration port decode
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_ADDR_W-1:2] == CFG_IDX_EXT_IRQ_COUNT);
    assign prdata  = cfg_sel ? DATA_W'(cfg_count_reg) : '0;

    // Cycle table: current entry, with bypass of a write that hit the read address
    assign tbl_entry = byp_valid_reg ? byp_data_reg : tbl_q;
    assign eff_count = (CNT_W'(cfg_count_reg) > CNT_W'(EXT_IRQ_DEPTH))
                       ? CNT_W'(EXT_IRQ_DEPTH) : CNT_W'(cfg_count_reg);
    assign pos_ext   = CNT_W'(pos_reg);
    assign tbl_we    = aresetn && fire && (op_reg == OP_TABLE_LOAD)
                       && (32'(idx_reg) < EXT_IRQ_DEPTH);
    assign tbl_waddr = AW'(idx_reg);
    assign tbl_raddr = aresetn ? pos_next : '0;

    itc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (EXT_IRQ_DEPTH)
    ) u_cycle_table (
        .clk   (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (val_reg),
        .raddr (tbl_raddr),
        .rdata (tbl_q)
    );

    // Item processing: compute result and next state for the item in the input register
    always_comb begin
        in_valid_next   = in_valid_reg;
        m_valid_next    = m_valid_reg;
        take_next       = take_reg;
        fetch_next      = fetch_reg;
        rdata_next      = rdata_reg;
        en_next         = en_reg;
        st_next         = st_reg;
        handler_next    = handler_reg;
        ret_next        = ret_reg;
        in_handler_next = in_handler_reg;
        timer_on_next   = timer_on_reg;
        timer_cnt_next  = timer_cnt_reg;
        timer_lim_next  = timer_lim_reg;
        cycle_next      = cycle_reg;
        disk_next       = disk_reg;
        pos_next        = pos_reg;

        // advance the input register
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end

        // advance the result register
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (fire) begin
            take_next  = 1'b0;
            fetch_next = pc_reg;
            rdata_next = '0;

            unique case (op_reg)
                OP_TICK: begin
                    // enter the handler on the statuses seen before this tick
                    if (!bigimm_reg && ((en_reg & st_reg) != '0) && !in_handler_reg) begin
                        in_handler_next = 1'b1;
                        ret_next        = pc_reg;
                        fetch_next      = handler_reg;
                        take_next       = 1'b1;
                    end
                    // external interrupt table match; last entry stays armed
                    if ((pos_ext < eff_count) && (cycle_reg == tbl_entry)) begin
                        st_next[SRC_EXT] = 1'b1;
                        if (pos_ext + CNT_W'(1) < eff_count) begin
                            pos_next = pos_reg + AW'(1);
                        end
                    end
                    // timer step
                    if (timer_on_reg) begin
                        if (timer_cnt_reg < timer_lim_reg) begin
                            timer_cnt_next = timer_cnt_reg + DATA_W'(1);
                        end else begin
                            st_next[SRC_TIMER] = 1'b1;
                            timer_cnt_next     = '0;
                        end
                    end
                    // disk tick whenever the cycle count is a multiple of the period
                    if (disk_reg == '0) begin
                        st_next[SRC_DISK] = 1'b1;
                    end
                    if (cycle_reg == '1) begin
                        disk_next = '0;
                    end else if (disk_reg == DISK_W'(DISK_PERIOD - 1)) begin
                        disk_next = '0;
                    end else begin
                        disk_next = disk_reg + DISK_W'(1);
                    end
                    cycle_next = cycle_reg + DATA_W'(1);
                end
                OP_IO_WRITE: begin
                    unique case (idx_reg)
                        IO_ENABLE0:   en_next[SRC_TIMER] = val_reg[0];
                        IO_ENABLE1:   en_next[SRC_DISK]  = val_reg[0];
                        IO_ENABLE2:   en_next[SRC_EXT]   = val_reg[0];
                        IO_STATUS0:   st_next[SRC_TIMER] = val_reg[0];
                        IO_STATUS1:   st_next[SRC_DISK]  = val_reg[0];
                        IO_STATUS2:   st_next[SRC_EXT]   = val_reg[0];
                        IO_HANDLER:   handler_next       = val_reg[PC_BITS-1:0];
                        IO_RETURN:    ret_next           = val_reg[PC_BITS-1:0];
                        IO_TIMER_ON:  timer_on_next      = val_reg[0];
                        IO_TIMER_CNT: timer_cnt_next     = val_reg;
                        IO_TIMER_LIM: timer_lim_next     = val_reg;
                        default: ;
                    endcase
                end
                OP_IO_READ: begin
                    unique case (idx_reg)
                        IO_ENABLE0:   rdata_next = DATA_W'(en_reg[SRC_TIMER]);
                        IO_ENABLE1:   rdata_next = DATA_W'(en_reg[SRC_DISK]);
                        IO_ENABLE2:   rdata_next = DATA_W'(en_reg[SRC_EXT]);
                        IO_STATUS0:   rdata_next = DATA_W'(st_reg[SRC_TIMER]);
                        IO_STATUS1:   rdata_next = DATA_W'(st_reg[SRC_DISK]);
                        IO_STATUS2:   rdata_next = DATA_W'(st_reg[SRC_EXT]);
                        IO_HANDLER:   rdata_next = DATA_W'(handler_reg);
                        IO_RETURN:    rdata_next = DATA_W'(ret_reg);
                        IO_TIMER_ON:  rdata_next = DATA_W'(timer_on_reg);
                        IO_TIMER_CNT: rdata_next = timer_cnt_reg;
                        IO_TIMER_LIM: rdata_next = timer_lim_reg;
                        IO_CYCLE_CNT: rdata_next = cycle_reg;
                        default:      rdata_next = '0;
                    endcase
                end
                OP_IRQ_RETURN: begin
                    in_handler_next = 1'b0;
                    fetch_next      = ret_reg;
                end
                default: ;
            endcase
        end
    end

    // Control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg  <= '0;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            en_reg         <= '0;
            st_reg         <= '0;
            handler_reg    <= '0;
            ret_reg        <= '0;
            in_handler_reg <= 1'b0;
            timer_on_reg   <= 1'b0;
            timer_cnt_reg  <= '0;
            timer_lim_reg  <= '0;
            cycle_reg      <= '0;
            disk_reg       <= '0;
            pos_reg        <= '0;
            byp_valid_reg  <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && cfg_sel) begin
                cfg_count_reg <= pwdata[CFG_CNT_W-1:0];
            end
            in_valid_reg   <= in_valid_next;
            m_valid_reg    <= m_valid_next;
            en_reg         <= en_next;
            st_reg         <= st_next;
            handler_reg    <= handler_next;
            ret_reg        <= ret_next;
            in_handler_reg <= in_handler_next;
            timer_on_reg   <= timer_on_next;
            timer_cnt_reg  <= timer_cnt_next;
            timer_lim_reg  <= timer_lim_next;
            cycle_reg      <= cycle_next;
            disk_reg       <= disk_next;
            pos_reg        <= pos_next;
            byp_valid_reg  <= tbl_we && (tbl_waddr == tbl_raddr);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_opcode;
            pc_reg     <= s_current_pc;
            bigimm_reg <= s_big_imm_pending;
            idx_reg    <= s_target_index;
            val_reg    <= s_write_value;
        end
        take_reg     <= take_next;
        fetch_reg    <= fetch_next;
        rdata_reg    <= rdata_next;
        byp_data_reg <= val_reg;
    end

endmodule

`default_nettype wire

// ===== hdl/itc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the external interrupt cycle table.
`default_nettype none

module itc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, returns the old contents on a same-address write
    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/itc_checker.sv =====
// Port-level checker for the interrupt and timer controller, bound to the top level.
// Depends on itc_pkg and irq_timer_controller_defines.svh.
`default_nettype none

`include "irq_timer_controller_defines.svh"

module itc_checker
    import itc_pkg::*;
#(
    parameter int PC_BITS = PC_BITS_DEF
) (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_take_interrupt,
    input wire logic [PC_BITS-1:0] m_fetch_pc,
    input wire logic [DATA_W-1:0]  m_read_data,
    input wire logic               psel,
    input wire logic [DATA_W-1:0]  prdata
);

    // Hold a stalled item unchanged
    `ITC_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready,
        m_valid && $stable(m_take_interrupt) && $stable(m_fetch_pc) && $stable(m_read_data),
        "stalled result item changed")

    // Drop the result channel during reset
    `ITC_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_valid,
        "result valid right after reset")

    // An interrupt entry is a tick, never a read
    `ITC_ASSERT_NOW(a_take_no_read, m_valid && m_take_interrupt, m_read_data == '0,
        "interrupt entry item carries read data")

    // An empty result register always leaves room for a new item
    `ITC_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready,
        "input not ready with empty result register")

    // Only the count bits of the configuration register read back
    `ITC_ASSERT_NOW(a_cfg_width, psel, prdata[DATA_W-1:CFG_CNT_W] == '0,
        "configuration read returns bits beyond the count")

endmodule

bind irq_timer_controller itc_checker #(
    .PC_BITS (PC_BITS)
) u_itc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_take_interrupt (m_take_interrupt),
    .m_fetch_pc       (m_fetch_pc),
    .m_read_data      (m_read_data),
    .psel             (psel),
    .prdata           (prdata)
);

`default_nettype wire

// ===== bench/tb_irq_timer_controller.sv =====
// Self-checking testbench for irq_timer_controller: random and directed cpu operations.
// Uses itc_pkg for codes and widths, and a scoreboard class that predicts each result.
module tb_irq_timer_controller
    import itc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PCW        = PC_BITS_DEF;
    localparam int MARK_DEPTH = EXT_IRQ_DEPTH_DEF;
    localparam int IDLE_LIMIT = 1000;
    localparam int PRINT_CAP  = 40;
    localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = {CFG_IDX_EXT_IRQ_COUNT, 2'b00};
    // Opcodes with no operation behind them
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [PCW-1:0]    current_pc;
        logic              big_imm_pending;
        logic [IDX_W-1:0]  target_index;
        logic [DATA_W-1:0] write_value;
    } cpu_op_t;

    typedef struct packed {
        logic              take_interrupt;
        logic [PCW-1:0]    fetch_pc;
        logic [DATA_W-1:0] read_data;
    } fetch_result_t;

    // Shadow of the controller state plus the results still owed by the block
    class itc_scoreboard;
        logic [IRQ_SRCS-1:0] irq_en      = '0;
        logic [IRQ_SRCS-1:0] irq_pend    = '0;
        logic [PCW-1:0]      vector_pc   = '0;
        logic [PCW-1:0]      resume_pc   = '0;
        bit                  servicing   = 1'b0;
        bit                  timer_run   = 1'b0;
        logic [DATA_W-1:0]   timer_val   = '0;
        logic [DATA_W-1:0]   timer_top   = '0;
        logic [DATA_W-1:0]   tick_count  = '0;
        int unsigned         ext_slot    = 0;
        int unsigned         marks_armed = 0;
        logic [DATA_W-1:0]   ext_marks [MARK_DEPTH];
        fetch_result_t       results_due [$];
        int unsigned         mismatches  = 0;

        function int unsigned pending();
            return results_due.size();
        endfunction

        function void set_mark_count(logic [CFG_CNT_W-1:0] n);
            marks_armed = n;
        endfunction

        // Step the shadow state by one accepted item and queue its result
        function void note_item(cpu_op_t op);
            fetch_result_t r;
            int unsigned   armed;
            r.take_interrupt = 1'b0;
            r.fetch_pc       = op.current_pc;
            r.read_data      = '0;
            case (op.opcode)
                OP_TICK: begin
                    // interrupt entry looks at the state before this tick
                    if (!op.big_imm_pending && (irq_en & irq_pend) != '0 && !servicing) begin
                        servicing        = 1'b1;
                        resume_pc        = op.current_pc;
                        r.fetch_pc       = vector_pc;
                        r.take_interrupt = 1'b1;
                    end
                    armed = (marks_armed > MARK_DEPTH) ? MARK_DEPTH : marks_armed;
                    // last armed entry stays put once reached
                    if (ext_slot < armed && tick_count == ext_marks[ext_slot]) begin
                        irq_pend[SRC_EXT] = 1'b1;
                        if (ext_slot + 1 < armed) ext_slot++;
                    end
                    if (timer_run) begin
                        if (timer_val < timer_top) begin
                            timer_val++;
                        end else begin
                            irq_pend[SRC_TIMER] = 1'b1;
                            timer_val           = '0;
                        end
                    end
                    if (tick_count % DISK_PERIOD_DEF == 0) irq_pend[SRC_DISK] = 1'b1;
                    tick_count++;
                end
                OP_IO_WRITE: begin
                    case (op.target_index)
                        IO_ENABLE0, IO_ENABLE1, IO_ENABLE2:
                            irq_en[2'(op.target_index)] = op.write_value[0];
                        IO_STATUS0, IO_STATUS1, IO_STATUS2:
                            irq_pend[2'(op.target_index - IO_STATUS0)] = op.write_value[0];
                        IO_HANDLER:   vector_pc = op.write_value[PCW-1:0];
                        IO_RETURN:    resume_pc = op.write_value[PCW-1:0];
                        IO_TIMER_ON:  timer_run = op.write_value[0];
                        IO_TIMER_CNT: timer_val = op.write_value;
                        IO_TIMER_LIM: timer_top = op.write_value;
                        default: ;
                    endcase
                end
                OP_IO_READ: begin
                    case (op.target_index)
                        IO_ENABLE0, IO_ENABLE1, IO_ENABLE2:
                            r.read_data = DATA_W'(irq_en[2'(op.target_index)]);
                        IO_STATUS0, IO_STATUS1, IO_STATUS2:
                            r.read_data = DATA_W'(irq_pend[2'(op.target_index - IO_STATUS0)]);
                        IO_HANDLER:   r.read_data = DATA_W'(vector_pc);
                        IO_RETURN:    r.read_data = DATA_W'(resume_pc);
                        IO_TIMER_ON:  r.read_data = DATA_W'(timer_run);
                        IO_TIMER_CNT: r.read_data = timer_val;
                        IO_TIMER_LIM: r.read_data = timer_top;
                        IO_CYCLE_CNT: r.read_data = tick_count;
                        default:      r.read_data = '0;
                    endcase
                end
                OP_IRQ_RETURN: begin
                    servicing  = 1'b0;
                    r.fetch_pc = resume_pc;
                end
                OP_TABLE_LOAD: ext_marks[op.target_index] = op.write_value;
                default: ;
            endcase
            results_due.push_back(r);
        endfunction

        task report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            if (mismatches < PRINT_CAP)
                $display("[%0t] mismatch, %s: got %h, want %h", $time, what, got, want);
            mismatches++;
        endtask

        // Compare one accepted result against the oldest prediction
        task check_result(fetch_result_t got);
            fetch_result_t want;
            if (results_due.size() == 0) begin
                report("result with nothing expected", DATA_W'(got.fetch_pc), '0);
            end else begin
                want = results_due.pop_front();
                if (got.take_interrupt !== want.take_interrupt)
                    report("take_interrupt", DATA_W'(got.take_interrupt),
                           DATA_W'(want.take_interrupt));
                if (got.fetch_pc !== want.fetch_pc)
                    report("fetch_pc", DATA_W'(got.fetch_pc), DATA_W'(want.fetch_pc));
                if (got.read_data !== want.read_data)
                    report("read_data", got.read_data, want.read_data);
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn           = 1'b0;
    logic                  s_valid           = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_opcode          = '0;
    logic [PCW-1:0]        s_current_pc      = '0;
    logic                  s_big_imm_pending = 1'b0;
    logic [IDX_W-1:0]      s_target_index    = '0;
    logic [DATA_W-1:0]     s_write_value     = '0;
    logic                  m_valid;
    logic                  m_ready           = 1'b0;
    logic                  m_take_interrupt;
    logic [PCW-1:0]        m_fetch_pc;
    logic [DATA_W-1:0]     m_read_data;
    logic                  psel              = 1'b0;
    logic                  penable           = 1'b0;
    logic                  pwrite            = 1'b0;
    logic [APB_ADDR_W-1:0] paddr             = '0;
    logic [DATA_W-1:0]     pwdata            = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    itc_scoreboard sb = new();
    bit            no_idle = 1'b0;
    int unsigned   idle_cycles = 0;

    irq_timer_controller u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_current_pc      (s_current_pc),
        .s_big_imm_pending (s_big_imm_pending),
        .s_target_index    (s_target_index),
        .s_write_value     (s_write_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_take_interrupt  (m_take_interrupt),
        .m_fetch_pc        (m_fetch_pc),
        .m_read_data       (m_read_data),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic cpu_op_t make_op(logic [OP_W-1:0] opc, logic [PCW-1:0] pc,
                                        logic bimm, logic [IDX_W-1:0] idx,
                                        logic [DATA_W-1:0] val);
        cpu_op_t op;
        op.opcode          = opc;
        op.current_pc      = pc;
        op.big_imm_pending = bimm;
        op.target_index    = idx;
        op.write_value     = val;
        return op;
    endfunction

    // Mostly ticks and handler traffic; register and table values kept near live state
    function automatic cpu_op_t random_op();
        cpu_op_t     op;
        int unsigned pick;
        int unsigned slot;
        op.opcode          = OP_TICK;
        op.current_pc      = PCW'($urandom());
        op.big_imm_pending = ($urandom_range(0, 6) == 0);
        op.target_index    = IDX_W'($urandom());
        op.write_value     = $urandom();
        pick = $urandom_range(0, 99);
        if (sb.servicing && pick < 25) begin
            // service the interrupt: acknowledge a source or leave the handler
            if (pick < 12) begin
                op.opcode         = OP_IO_WRITE;
                op.target_index   = IO_STATUS0 + IDX_W'($urandom_range(0, IRQ_SRCS - 1));
                op.write_value[0] = 1'b0;
            end else begin
                op.opcode = OP_IRQ_RETURN;
            end
            return op;
        end
        if (pick >= 45 && pick < 80) begin
            op.opcode = (pick < 65) ? OP_IO_WRITE : OP_IO_READ;
            if ($urandom_range(0, 5) != 0) op.target_index = IDX_W'($urandom_range(0, 11));
            if (op.target_index == IO_TIMER_LIM && $urandom_range(0, 3) != 0)
                op.write_value = $urandom_range(0, 24);
            if (op.target_index == IO_TIMER_CNT && $urandom_range(0, 3) != 0)
                op.write_value = $urandom_range(0, 30);
        end else if (pick >= 80 && pick < 90) begin
            op.opcode = OP_TABLE_LOAD;
            // re-arm the slot in use or one of the two after it with a cycle number a little ahead
            if ($urandom_range(0, 3) != 0) begin
                slot = sb.ext_slot + $urandom_range(0, 2);
                op.target_index = IDX_W'((slot > MARK_DEPTH - 1) ? MARK_DEPTH - 1 : slot);
                op.write_value  = sb.tick_count + $urandom_range(0, 40);
            end
        end else if (pick >= 90 && pick < 97) begin
            op.opcode = OP_IRQ_RETURN;
        end else if (pick >= 97) begin
            op.opcode = OP_W'($urandom_range(32'(OP_SPARE_LO), 32'(OP_SPARE_HI)));
        end
        return op;
    endfunction

    // Present one item, hold it until accepted; valid stays high on return
    task automatic offer_op(cpu_op_t op);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_opcode          <= op.opcode;
        s_current_pc      <= op.current_pc;
        s_big_imm_pending <= op.big_imm_pending;
        s_target_index    <= op.target_index;
        s_write_value     <= op.write_value;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        sb.note_item(op);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the table count, then read it back over the same port
    task automatic program_table_count(logic [CFG_CNT_W-1:0] n);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COUNT_ADDR;
        pwdata  <= DATA_W'(n);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        sb.set_mark_count(n);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        if (prdata !== DATA_W'(n)) sb.report("table count readback", prdata, DATA_W'(n));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stalls, check every accepted item
    initial begin
        fetch_result_t got;
        int unsigned   stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait();
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            got.take_interrupt = m_take_interrupt;
            got.fetch_pc       = m_fetch_pc;
            got.read_data      = m_read_data;
            sb.check_result(got);
        end
    end

    // Give up when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid & s_ready) === 1'b1 || (m_valid & m_ready) === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        cpu_op_t     directed [$];
        int unsigned count_plan [6];
        count_plan = '{3, 64, 127, 0, 2, 40};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table: no comparisons at all
        program_table_count('0);

        // register map corners, interrupt entry and return, timer wrap
        directed.push_back(make_op(OP_IO_READ,    12'h000, 1'b0, IO_CYCLE_CNT, 32'h0));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_CYCLE_CNT, 32'hFFFF_FFFF));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, 6'h3F,        32'hFFFF_FFFF));
        directed.push_back(make_op(OP_IO_READ,    12'hFFF, 1'b0, 6'h3F,        32'h0));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_HANDLER,   32'hFFFF_FFFF));
        directed.push_back(make_op(OP_IO_READ,    12'h000, 1'b0, IO_HANDLER,   32'h0));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_RETURN,    32'h0000_0ABC));
        directed.push_back(make_op(OP_IRQ_RETURN, 12'h000, 1'b0, 6'h00,        32'h0));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_ENABLE0,   32'hFFFF_FFFF));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_ENABLE1,   32'hFFFF_FFFF));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_ENABLE2,   32'hFFFF_FFFF));
        directed.push_back(make_op(OP_TICK,       12'h123, 1'b0, 6'h00,        32'h0));
        directed.push_back(make_op(OP_TICK,       12'hFFF, 1'b1, 6'h3F,        32'hFFFF_FFFF));
        directed.push_back(make_op(OP_TICK,       12'h456, 1'b0, 6'h00,        32'h0));
        directed.push_back(make_op(OP_TICK,       12'h789, 1'b0, 6'h00,        32'h0));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_STATUS1,   32'hFFFF_FFFE));
        directed.push_back(make_op(OP_IRQ_RETURN, 12'h000, 1'b0, 6'h00,        32'h0));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_TIMER_LIM, 32'hFFFF_FFFF));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_TIMER_CNT, 32'hFFFF_FFFE));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_TIMER_ON,  32'h0000_0001));
        directed.push_back(make_op(OP_TICK,       12'h010, 1'b0, 6'h00,        32'h0));
        directed.push_back(make_op(OP_TICK,       12'h011, 1'b0, 6'h00,        32'h0));
        directed.push_back(make_op(OP_IO_READ,    12'h000, 1'b0, IO_TIMER_CNT, 32'h0));
        directed.push_back(make_op(OP_IO_WRITE,   12'h000, 1'b0, IO_TIMER_LIM, 32'h0));
        directed.push_back(make_op(OP_TICK,       12'h012, 1'b0, 6'h00,        32'h0));
        directed.push_back(make_op(OP_SPARE_HI,   12'hFFF, 1'b1, 6'h3F,        32'hFFFF_FFFF));
        directed.push_back(make_op(OP_SPARE_LO,   12'h0A5, 1'b0, 6'h15,        32'h5A5A_5A5A));
        foreach (directed[i]) offer_op(directed[i]);

        // fill every table slot before any count can expose one
        for (int i = 0; i < MARK_DEPTH; i++)
            offer_op(make_op(OP_TABLE_LOAD, PCW'($urandom()), 1'b0, IDX_W'(i),
                             sb.tick_count + DATA_W'(8 + 2 * i)));

        foreach (count_plan[p]) begin
            drain_results();
            program_table_count(CFG_CNT_W'(count_plan[p]));
            for (int n = 0; n < 170; n++) begin
                if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
                // hold off new items until the block has emptied
                if (p == 0 && n == 85) drain_results();
                offer_op(random_op());
            end
        end
        no_idle = 1'b0;

        drain_results();
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/itc_pkg.sv
hdl/itc_ram.sv
hdl/irq_timer_controller.sv
hdl/itc_checker.sv
bench/tb_irq_timer_controller.sv
